### hw/rtl/free_space_map_allocator_assert.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FREE_SPACE_MAP_ALLOCATOR_ASSERT_SVH
`define FREE_SPACE_MAP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSMAP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FSMAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/fsmap_pkg.sv
`timescale 1ns / 1ps

package fsmap_pkg;

  localparam int DEF_MAX_PAGES = 8192;
  localparam int LANES = 16;
  localparam logic [15:0] UPB_RESET = 16'd4064;
  localparam logic [4:0] CLASS_MAX = 5'd15;
  // 2^19 / 15 rounded up; exact for every 16-bit dividend.
  localparam logic [31:0] RECIP_15 = 32'd34953;
  localparam int RECIP_SHIFT = 19;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_SET = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [1:0] OUT_OK = 2'd0;
  localparam logic [1:0] OUT_TOO_BIG = 2'd1;
  localparam logic [1:0] OUT_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [15:0] bytes_needed;
    logic [12:0] page_index;
    logic [3:0] class_value;
    logic [13:0] page_count;
  } in_item_t;

  typedef struct packed {
    logic [12:0] result_page;
    logic [3:0] result_class;
    logic [1:0] outcome;
    logic appended;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic too_big;
    logic [3:0] cls;
  } rcls_res_t;

  typedef enum logic [1:0] {
    RC_IDLE,
    RC_BKT,
    RC_RUN
  } rcls_state_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CLS,
    ST_SCAN,
    ST_WRD_RD,
    ST_WRD_USE,
    ST_FIN
  } ctrl_state_t;

endpackage

### hw/rtl/fsmap_mem.sv
`timescale 1ns / 1ps

module fsmap_mem #(
  parameter int DEPTH = 512,
  parameter int AW = 9
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0] wdata,
  input  logic re,
  input  logic [AW-1:0] raddr,
  output logic [63:0] rdata
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/fsmap_rcls.sv
`timescale 1ns / 1ps

module fsmap_rcls (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [15:0] bytes,
  input  logic [15:0] upb,
  output fsmap_pkg::rcls_res_t res
);
  import fsmap_pkg::*;

  rcls_state_t st_r, st_nxt;
  logic [15:0] bytes_r, bytes_nxt;
  logic [15:0] bucket_r, bucket_nxt;
  logic [19:0] acc_r, acc_nxt;
  logic [4:0] k_r, k_nxt;
  rcls_res_t res_r, res_nxt;
  logic [31:0] prod;
  logic [15:0] quot;

  assign prod = 32'(upb) * RECIP_15;
  assign quot = 16'(prod >> RECIP_SHIFT);
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= RC_IDLE;
      res_r <= '0;
    end else begin
      st_r <= st_nxt;
      res_r <= res_nxt;
    end
    bytes_r <= bytes_nxt;
    bucket_r <= bucket_nxt;
    acc_r <= acc_nxt;
    k_r <= k_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    bytes_nxt = bytes_r;
    bucket_nxt = bucket_r;
    acc_nxt = acc_r;
    k_nxt = k_r;
    res_nxt = res_r;
    res_nxt.done = 1'b0;
    case (st_r)
      RC_IDLE: begin
        if (start) begin
          bytes_nxt = bytes;
          st_nxt = RC_BKT;
        end
      end
      RC_BKT: begin
        // A page register below fifteen would give a zero bucket.
        bucket_nxt = (quot == '0) ? 16'd1 : quot;
        acc_nxt = '0;
        k_nxt = '0;
        if (bytes_r > upb) begin
          res_nxt = '{done: 1'b1, too_big: 1'b1, cls: 4'd0};
          st_nxt = RC_IDLE;
        end else begin
          st_nxt = RC_RUN;
        end
      end
      RC_RUN: begin
        // Smallest k with k * bucket >= bytes is the ceiling quotient.
        if (acc_r >= 20'(bytes_r)) begin
          res_nxt = '{done: 1'b1, too_big: 1'b0, cls: k_r[3:0]};
          st_nxt = RC_IDLE;
        end else if (k_r == CLASS_MAX) begin
          res_nxt = '{done: 1'b1, too_big: 1'b1, cls: 4'd0};
          st_nxt = RC_IDLE;
        end else begin
          acc_nxt = acc_r + 20'(bucket_r);
          k_nxt = k_r + 5'd1;
        end
      end
      default: st_nxt = RC_IDLE;
    endcase
  end

endmodule

### hw/rtl/fsmap_ctrl.sv
`timescale 1ns / 1ps

module fsmap_ctrl #(
  parameter int MAX_PAGES = fsmap_pkg::DEF_MAX_PAGES,
  parameter int AW = 9
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  fsmap_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output fsmap_pkg::out_item_t out_data,
  output logic rc_start,
  input  fsmap_pkg::rcls_res_t rc_res,
  output logic mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [63:0] mem_wdata,
  output logic mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [63:0] mem_rdata
);
  import fsmap_pkg::*;

  localparam int NWORDS = (MAX_PAGES + LANES - 1) / LANES;
  localparam int IW = AW + 4;
  localparam int XW = AW + 5;
  localparam int CW = $clog2(MAX_PAGES + 1);

  ctrl_state_t st_r, st_nxt;
  in_item_t item_r, item_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [3:0] req_r, req_nxt;
  logic [CW-1:0] piu_r, piu_nxt;
  logic [AW:0] ra_r, ra_nxt;
  logic rv_r, rv_nxt;
  logic [AW-1:0] ca_r, ca_nxt;
  logic [IW-1:0] op_page_r, op_page_nxt;
  logic [AW-1:0] clr_a_r, clr_a_nxt;
  logic clr_out_r, clr_out_nxt;

  logic [XW-1:0] nw;
  logic hit;
  logic [3:0] hit_lane;
  logic [3:0] hit_sum;
  logic [63:0] hit_word;
  logic [63:0] put_word;
  logic [4:0] sum;
  logic [3:0] op_lane;

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign op_lane = op_page_r[3:0];
  assign nw = XW'((XW'(piu_r) + XW'(LANES - 1)) >> 4);

  // First lane in use of the returned word whose class still takes the request.
  always_comb begin
    hit = 1'b0;
    hit_lane = '0;
    hit_sum = '0;
    sum = '0;
    for (int j = 0; j < LANES; j++) begin
      sum = {1'b0, mem_rdata[4*j +: 4]} + {1'b0, req_r};
      if (!hit && !sum[4] && (XW'({ca_r, 4'(j)}) < XW'(piu_r))) begin
        hit = 1'b1;
        hit_lane = 4'(j);
        hit_sum = sum[3:0];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      hit_word[4*j +: 4] = (4'(j) == hit_lane) ? hit_sum : mem_rdata[4*j +: 4];
      put_word[4*j +: 4] = (4'(j) == op_lane) ? res_r.result_class : mem_rdata[4*j +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR;
      out_valid_r <= 1'b0;
      piu_r <= '0;
      rv_r <= 1'b0;
      clr_a_r <= '0;
      clr_out_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= out_valid_nxt;
      piu_r <= piu_nxt;
      rv_r <= rv_nxt;
      clr_a_r <= clr_a_nxt;
      clr_out_r <= clr_out_nxt;
    end
    item_r <= item_nxt;
    res_r <= res_nxt;
    out_data_r <= out_data_nxt;
    req_r <= req_nxt;
    ra_r <= ra_nxt;
    ca_r <= ca_nxt;
    op_page_r <= op_page_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    item_nxt = item_r;
    res_nxt = res_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r;
    req_nxt = req_r;
    piu_nxt = piu_r;
    ra_nxt = ra_r;
    rv_nxt = rv_r;
    ca_nxt = ca_r;
    op_page_nxt = op_page_r;
    clr_a_nxt = clr_a_r;
    clr_out_nxt = clr_out_r;
    in_stall = 1'b1;
    rc_start = 1'b0;
    mem_we = 1'b0;
    mem_waddr = clr_a_r;
    mem_wdata = '0;
    mem_re = 1'b0;
    mem_raddr = ra_r[AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_CLR: begin
        mem_we = 1'b1;
        clr_a_nxt = clr_a_r + AW'(1);
        if (clr_a_r == AW'(NWORDS - 1)) begin
          clr_a_nxt = '0;
          st_nxt = clr_out_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt = '0;
          case (in_data.func)
            FUNC_ALLOC: begin
              rc_start = 1'b1;
              st_nxt = ST_CLS;
            end
            FUNC_SET, FUNC_READ: begin
              op_page_nxt = IW'(in_data.page_index);
              res_nxt.result_page = in_data.page_index;
              if (in_data.func == FUNC_SET) begin
                res_nxt.result_class = in_data.class_value;
              end
              if ({4'b0, in_data.page_index} < 17'(MAX_PAGES)) begin
                st_nxt = ST_WRD_RD;
              end else begin
                st_nxt = ST_FIN;
              end
            end
            default: begin
              if ({3'b0, in_data.page_count} >= 17'(MAX_PAGES)) begin
                piu_nxt = CW'(MAX_PAGES);
              end else begin
                piu_nxt = CW'(in_data.page_count);
              end
              clr_out_nxt = 1'b1;
              clr_a_nxt = '0;
              st_nxt = ST_CLR;
            end
          endcase
        end
      end
      ST_CLS: begin
        if (rc_res.done) begin
          if (rc_res.too_big) begin
            res_nxt.outcome = OUT_TOO_BIG;
            st_nxt = ST_FIN;
          end else begin
            req_nxt = rc_res.cls;
            ra_nxt = '0;
            rv_nxt = 1'b0;
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // One word of sixteen pages is issued per cycle and checked in the next cycle.
        if (XW'(ra_r) < nw) begin
          mem_re = 1'b1;
          ra_nxt = ra_r + (AW+1)'(1);
          rv_nxt = 1'b1;
          ca_nxt = ra_r[AW-1:0];
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r && hit) begin
          mem_we = 1'b1;
          mem_waddr = ca_r;
          mem_wdata = hit_word;
          res_nxt.result_page = 13'({ca_r, hit_lane});
          res_nxt.result_class = hit_sum;
          rv_nxt = 1'b0;
          st_nxt = ST_FIN;
        end else if (!rv_r && (XW'(ra_r) >= nw)) begin
          if (XW'(piu_r) < XW'(MAX_PAGES)) begin
            op_page_nxt = IW'(piu_r);
            res_nxt.result_page = 13'(piu_r);
            res_nxt.result_class = req_r;
            res_nxt.appended = 1'b1;
            piu_nxt = piu_r + CW'(1);
            st_nxt = ST_WRD_RD;
          end else begin
            res_nxt.outcome = OUT_FULL;
            st_nxt = ST_FIN;
          end
        end
      end
      ST_WRD_RD: begin
        mem_re = 1'b1;
        mem_raddr = op_page_r[IW-1:4];
        st_nxt = ST_WRD_USE;
      end
      ST_WRD_USE: begin
        if (item_r.func == FUNC_READ) begin
          res_nxt.result_class = mem_rdata[{op_lane, 2'b00} +: 4];
        end else begin
          // Set and append both place the class held in the result.
          mem_we = 1'b1;
          mem_waddr = op_page_r[IW-1:4];
          mem_wdata = put_word;
        end
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt = res_r;
          out_valid_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/free_space_map_allocator.sv
`timescale 1ns / 1ps

// Free-space map with first-fit page allocation. Classes are kept sixteen to a
// 64-bit word of one on-chip memory, so the map needs MAX_PAGES/16 words. An
// allocate transaction first forms the request class, trying the classes one
// by one, then scans the words in use at one cycle per sixteen pages of the
// memory read port, plus a read and a write for an append. Set and read each
// read the page's word, and a set writes it back. A clear transaction and the
// release from reset both sweep the memory one word per cycle with in_stall
// high. Only one transaction is worked on at a time; a finished result waits
// in the output register while the next transaction is taken. The
// configuration register may be written only while the block is idle.
module free_space_map_allocator #(
  parameter int MAX_PAGES = fsmap_pkg::DEF_MAX_PAGES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  fsmap_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output fsmap_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata
);
  import fsmap_pkg::*;

  localparam int NWORDS = (MAX_PAGES + LANES - 1) / LANES;
  localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  logic [15:0] upb_r;
  logic rc_start;
  rcls_res_t rc_res;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0] mem_wdata;
  logic mem_re;
  logic [AW-1:0] mem_raddr;
  logic [63:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upb_r <= UPB_RESET;
    end else if (cfg_we) begin
      upb_r <= cfg_wdata;
    end
  end

  fsmap_rcls u_rcls (
    .clk(clk),
    .rst_n(rst_n),
    .start(rc_start),
    .bytes(in_data.bytes_needed),
    .upb(upb_r),
    .res(rc_res)
  );

  fsmap_mem #(
    .DEPTH(NWORDS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  fsmap_ctrl #(
    .MAX_PAGES(MAX_PAGES),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .rc_start(rc_start),
    .rc_res(rc_res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

endmodule

### hw/rtl/fsmap_chk.sv
`timescale 1ns / 1ps
`include "free_space_map_allocator_assert.svh"

module fsmap_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input fsmap_pkg::in_item_t in_data,
  input logic out_valid,
  input logic out_stall,
  input fsmap_pkg::out_item_t out_data
);
  import fsmap_pkg::*;

  logic err_clean;

  assign err_clean = (out_data.result_page == 13'd0) && (out_data.result_class == 4'd0)
                     && !out_data.appended;

  // A result held back by the receiver stays put.
  `FSMAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // A stalled transaction on the input side stays put as well.
  `FSMAP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))
  // One transaction at a time: taking one closes the input.
  `FSMAP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // Error results carry no page, class or append flag.
  `FSMAP_ASSERT_SAME(a_err_clean, out_valid && (out_data.outcome != OUT_OK), err_clean)
  // Only a successful allocate appends.
  `FSMAP_ASSERT_SAME(a_append_ok, out_valid && out_data.appended, out_data.outcome == OUT_OK)

endmodule

bind free_space_map_allocator fsmap_chk u_fsmap_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);
